// File: src/smec_pkg.sv
// ----------------------------------------------------------------------------
// Stepper move controller package
// Item kinds, register indexes, register widths and reset values.
// ----------------------------------------------------------------------------
package smec_pkg;

  // Kind of an input item.
  typedef enum logic [1:0] {
    KIND_TICK        = 2'd0,
    KIND_MOVE_STEPS  = 2'd1,
    KIND_MOVE_ANGLE  = 2'd2,
    KIND_SAMPLE      = 2'd3
  } kind_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_STEP = 1'd1;

  // Ratio registers, unsigned Q16.
  localparam int SPC_W = 22;
  localparam int CPS_W = 24;
  localparam logic [SPC_W-1:0] SPC_RESET = 22'd51200;
  localparam logic [CPS_W-1:0] CPS_RESET = 24'd83886;

  // Default sizes of the datapath.
  localparam int DEF_STEP_BITS   = 24;
  localparam int DEF_ANGLE_BITS  = 12;
  localparam int DEF_PERIOD_BITS = 16;

endpackage

// File: src/stepper_move_with_encoder_check.sv
// ----------------------------------------------------------------------------
// Stepper move with encoder check
// Step/direction generator whose remaining count is corrected by encoder items.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register and passes the datapath into
// the result registers as soon as the result register is free or is being
// emptied. Throughput: one item per cycle while the result side does not stall,
// set by the single pass from the input register through the multipliers.
// Reset (synchronous, active high) clears the move state, loads the ratio
// registers with their defaults and empties both the input and result stages.
module stepper_move_with_encoder_check
  import smec_pkg::*;
#(
  parameter int STEP_BITS   = DEF_STEP_BITS,
  parameter int ANGLE_BITS  = DEF_ANGLE_BITS,
  parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic signed [STEP_BITS-1:0]   step_count,
  input  logic [ANGLE_BITS:0]           target_angle,
  input  logic [PERIOD_BITS-1:0]        period_ticks,
  input  logic [ANGLE_BITS-1:0]         encoder_angle,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          step_pulse,
  output logic                          direction,
  output logic                          busy_res,
  output logic                          at_target,
  output logic signed [STEP_BITS-1:0]   missed_steps,
  output logic [STEP_BITS-1:0]          steps_left,
  output logic [ANGLE_BITS:0]           tracked_angle
);

  // Widths of the internal arithmetic. The goal angle of a move by steps is
  // the rounded product of the count and the counts-per-step ratio.
  localparam int GOAL_RAW_W = STEP_BITS + CPS_W - 16;
  localparam int GOAL_W     = (GOAL_RAW_W > ANGLE_BITS + 2) ? GOAL_RAW_W : ANGLE_BITS + 2;
  localparam int D_W        = GOAL_W + 1;
  localparam int P1_W       = STEP_BITS + CPS_W + 1;
  localparam int P2_W       = D_W + SPC_W + 1;
  localparam int AD_W       = ANGLE_BITS + 2;

  localparam logic [STEP_BITS-1:0]     STEP_CAP  = {1'b1, {(STEP_BITS-1){1'b0}}};
  localparam logic [STEP_BITS-1:0]     MISS_MAX  = {1'b0, {(STEP_BITS-1){1'b1}}};
  localparam logic [ANGLE_BITS:0]      FULL_TURN = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic signed [AD_W-1:0]   HALF_POS  = AD_W'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [AD_W-1:0]   HALF_NEG  = -HALF_POS;
  localparam logic [PERIOD_BITS-1:0]   PERIOD_ONE = PERIOD_BITS'(1);

  // Ratio registers.
  logic [SPC_W-1:0] steps_per_count_q16;
  logic [CPS_W-1:0] counts_per_step_q16;

  // Move state.
  logic [STEP_BITS-1:0]      remaining_steps, remaining_steps_next;
  logic [PERIOD_BITS-1:0]    tick_countdown, tick_countdown_next;
  logic [PERIOD_BITS-1:0]    step_period, step_period_next;
  logic                      dir_flag, dir_flag_next;
  logic signed [GOAL_W-1:0]  goal_angle, goal_angle_next;
  logic [ANGLE_BITS:0]       angle_now, angle_now_next;
  logic                      moving, moving_next;

  // Input stage.
  logic                        held_valid;
  kind_t                       held_kind;
  logic signed [STEP_BITS-1:0] held_step_count;
  logic [ANGLE_BITS:0]         held_target;
  logic [PERIOD_BITS-1:0]      held_period;
  logic [ANGLE_BITS-1:0]       held_encoder;

  logic advance;

  // The datapath fires whenever an item is held and the result register is
  // free or being emptied in this cycle; the input stage refills behind it.
  assign advance   = held_valid && (!out_valid || out_ready);
  assign in_ready  = !held_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_count_q16 <= SPC_RESET;
      counts_per_step_q16 <= CPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEPS_PER_COUNT: steps_per_count_q16 <= cfg_data[SPC_W-1:0];
        CFG_COUNTS_PER_STEP: counts_per_step_q16 <= cfg_data[CPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_kind       <= kind_t'(kind);
      held_step_count <= step_count;
      held_target     <= target_angle;
      held_period     <= period_ticks;
      held_encoder    <= encoder_angle;
    end
  end

  // Encoder sample: a jump of more than half a turn clamps the tracked angle
  // to the end of the turn it came from.
  logic signed [AD_W-1:0] ang_diff;
  logic [ANGLE_BITS:0]    ang_sampled;

  assign ang_diff = $signed({1'b0, angle_now}) - $signed({2'b00, held_encoder});

  always_comb begin
    if (ang_diff > HALF_POS) begin
      ang_sampled = FULL_TURN;
    end else if (ang_diff < HALF_NEG) begin
      ang_sampled = '0;
    end else begin
      ang_sampled = {1'b0, held_encoder};
    end
  end

  // Steps still needed to reach the goal, from the freshly sampled angle.
  // A move to an angle takes its goal from the item itself.
  logic signed [GOAL_W-1:0] goal_sel;
  logic signed [D_W-1:0]    goal_diff;
  logic signed [P2_W-1:0]   p2;
  logic                     p2_neg;
  logic [P2_W-1:0]          p2_mag;
  logic [P2_W:0]            r2;
  logic [P2_W-16:0]         r2_mag;
  logic [STEP_BITS-1:0]     expected;

  assign goal_sel  = (held_kind == KIND_MOVE_ANGLE) ? $signed(GOAL_W'(held_target)) : goal_angle;
  assign goal_diff = D_W'(goal_sel) - $signed(D_W'(ang_sampled));
  assign p2        = goal_diff * $signed({1'b0, steps_per_count_q16});
  assign p2_neg    = p2[P2_W-1];
  assign p2_mag    = p2_neg ? P2_W'(-p2) : P2_W'(p2);
  assign r2        = (P2_W+1)'(p2_mag) + (P2_W+1)'(32768);
  assign r2_mag    = r2[P2_W:16];
  assign expected  = (r2_mag > (P2_W-15)'(STEP_CAP)) ? STEP_CAP : r2_mag[STEP_BITS-1:0];

  // Goal angle of a move by steps, rounded half away from zero.
  logic signed [P1_W-1:0]   p1;
  logic                     p1_neg;
  logic [P1_W-1:0]          p1_mag;
  logic [P1_W:0]            r1;
  logic [GOAL_W-1:0]        r1_mag;
  logic signed [GOAL_W-1:0] goal_from_steps;
  logic [STEP_BITS-1:0]     count_mag;

  assign p1              = held_step_count * $signed({1'b0, counts_per_step_q16});
  assign p1_neg          = p1[P1_W-1];
  assign p1_mag          = p1_neg ? P1_W'(-p1) : P1_W'(p1);
  assign r1              = (P1_W+1)'(p1_mag) + (P1_W+1)'(32768);
  assign r1_mag          = GOAL_W'(r1[P1_W:16]);
  assign goal_from_steps = p1_neg ? -$signed(r1_mag) : $signed(r1_mag);
  assign count_mag       = held_step_count[STEP_BITS-1] ? STEP_BITS'(-held_step_count)
                                                        : held_step_count;

  // Correction reported on a sample, saturated to the signed step width.
  logic signed [STEP_BITS:0]  miss_wide;
  logic signed [STEP_BITS-1:0] miss_sat;

  assign miss_wide = $signed({1'b0, expected}) - $signed({1'b0, remaining_steps});
  assign miss_sat  = (miss_wide > $signed({1'b0, MISS_MAX})) ? $signed(MISS_MAX)
                                                              : miss_wide[STEP_BITS-1:0];

  logic [PERIOD_BITS-1:0]      period_eff;
  logic                        pulse_next;
  logic                        at_target_next;
  logic signed [STEP_BITS-1:0] missed_next;

  assign period_eff = (held_period == '0) ? PERIOD_ONE : held_period;

  always_comb begin
    remaining_steps_next = remaining_steps;
    tick_countdown_next  = tick_countdown;
    step_period_next     = step_period;
    dir_flag_next        = dir_flag;
    goal_angle_next      = goal_angle;
    angle_now_next       = angle_now;
    moving_next          = moving;
    pulse_next           = 1'b0;
    at_target_next       = 1'b0;
    missed_next          = '0;
    case (held_kind)
      KIND_TICK: begin
        if (moving) begin
          if (remaining_steps == '0) begin
            moving_next = 1'b0;
          end else if (tick_countdown == '0) begin
            pulse_next           = 1'b1;
            remaining_steps_next = remaining_steps - STEP_BITS'(1);
            tick_countdown_next  = step_period - PERIOD_ONE;
            if (remaining_steps == STEP_BITS'(1)) begin
              moving_next = 1'b0;
            end
          end else begin
            tick_countdown_next = tick_countdown - PERIOD_ONE;
          end
        end
      end
      KIND_MOVE_STEPS: begin
        goal_angle_next     = goal_from_steps;
        step_period_next    = period_eff;
        tick_countdown_next = '0;
        if (held_step_count == '0) begin
          remaining_steps_next = '0;
          moving_next          = 1'b0;
        end else begin
          dir_flag_next        = held_step_count[STEP_BITS-1];
          remaining_steps_next = count_mag;
          moving_next          = 1'b1;
        end
      end
      KIND_MOVE_ANGLE: begin
        goal_angle_next     = $signed(GOAL_W'(held_target));
        angle_now_next      = ang_sampled;
        step_period_next    = period_eff;
        tick_countdown_next = '0;
        if (expected == '0) begin
          remaining_steps_next = '0;
          moving_next          = 1'b0;
        end else begin
          dir_flag_next        = p2_neg;
          remaining_steps_next = expected;
          moving_next          = 1'b1;
        end
      end
      default: begin
        // Encoder sample: the direction and the moving flag stay as they are.
        angle_now_next = ang_sampled;
        if (expected == '0) begin
          at_target_next = 1'b1;
        end else begin
          missed_next          = miss_sat;
          remaining_steps_next = expected;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_steps <= '0;
      tick_countdown  <= '0;
      step_period     <= PERIOD_ONE;
      dir_flag        <= 1'b1;
      goal_angle      <= '0;
      angle_now       <= '0;
      moving          <= 1'b0;
    end else if (advance) begin
      remaining_steps <= remaining_steps_next;
      tick_countdown  <= tick_countdown_next;
      step_period     <= step_period_next;
      dir_flag        <= dir_flag_next;
      goal_angle      <= goal_angle_next;
      angle_now       <= angle_now_next;
      moving          <= moving_next;
    end
  end

  // Result register: loaded as the item leaves the datapath, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step_pulse    <= pulse_next;
      direction     <= dir_flag_next;
      busy_res      <= moving_next;
      at_target     <= at_target_next;
      missed_steps  <= missed_next;
      steps_left    <= remaining_steps_next;
      tracked_angle <= angle_now_next;
    end
  end

`ifndef SYNTHESIS
  // A move by a non-zero count always starts a move.
  a_move_starts: assert property (@(posedge clk) disable iff (rst)
    advance && held_kind == KIND_MOVE_STEPS && held_step_count != '0 |=> moving)
    else $error("non-zero move did not start");

  // A due tick during a move with steps left must produce a step.
  a_tick_steps: assert property (@(posedge clk) disable iff (rst)
    advance && held_kind == KIND_TICK && moving && remaining_steps != '0
      && tick_countdown == '0 |=> out_valid && step_pulse)
    else $error("due tick issued no step");

  // An accepted item is always held in the input stage in the next cycle.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> held_valid)
    else $error("accepted item lost");

  // The tracked angle never exceeds a full turn.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    advance |=> angle_now <= FULL_TURN)
    else $error("tracked angle beyond a full turn");
`endif

endmodule

// File: tb/tb_stepper_move_with_encoder_check.sv
// ----------------------------------------------------------------------------
// Testbench for the stepper move controller with encoder check
// Directed moves and encoder items, then shaped random traffic under several
// ratio settings. Every result is checked against a cycle-free model of the
// move state, with random gaps on the sending side and stalls on the result
// side.
// ----------------------------------------------------------------------------
module tb_stepper_move_with_encoder_check;
  import smec_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  // Largest magnitude that any step count may take.
  localparam longint STEP_CAP    = 64'sd1 <<< (DEF_STEP_BITS - 1);
  localparam longint FULL_TURN   = 64'sd1 <<< DEF_ANGLE_BITS;
  localparam longint HALF_TURN   = FULL_TURN >>> 1;
  localparam int     MAX_ANGLE   = (1 << DEF_ANGLE_BITS) - 1;

  // One input item, as it stands on the input ports.
  typedef struct {
    kind_t                              kind;
    logic signed [DEF_STEP_BITS-1:0]    step_count;
    logic [DEF_ANGLE_BITS:0]            target_angle;
    logic [DEF_PERIOD_BITS-1:0]         period_ticks;
    logic [DEF_ANGLE_BITS-1:0]          encoder_angle;
  } motor_item_t;

  // One result item: the motor status after an input item.
  typedef struct {
    logic                               step_pulse;
    logic                               direction;
    logic                               busy_res;
    logic                               at_target;
    logic signed [DEF_STEP_BITS-1:0]    missed_steps;
    logic [DEF_STEP_BITS-1:0]           steps_left;
    logic [DEF_ANGLE_BITS:0]            tracked_angle;
  } motor_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_STEPS_PER_COUNT;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  kind = KIND_TICK;
  logic signed [DEF_STEP_BITS-1:0] step_count = '0;
  logic [DEF_ANGLE_BITS:0]     target_angle = '0;
  logic [DEF_PERIOD_BITS-1:0]  period_ticks = '0;
  logic [DEF_ANGLE_BITS-1:0]   encoder_angle = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        step_pulse;
  logic                        direction;
  logic                        busy_res;
  logic                        at_target;
  logic signed [DEF_STEP_BITS-1:0] missed_steps;
  logic [DEF_STEP_BITS-1:0]    steps_left;
  logic [DEF_ANGLE_BITS:0]     tracked_angle;

  stepper_move_with_encoder_check dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .step_count    (step_count),
    .target_angle  (target_angle),
    .period_ticks  (period_ticks),
    .encoder_angle (encoder_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .step_pulse    (step_pulse),
    .direction     (direction),
    .busy_res      (busy_res),
    .at_target     (at_target),
    .missed_steps  (missed_steps),
    .steps_left    (steps_left),
    .tracked_angle (tracked_angle)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the move state. It is advanced once for every accepted item and
  // gives the status that the block must report for that item.
  // --------------------------------------------------------------------------
  logic [SPC_W-1:0]            spc_ratio;
  logic [CPS_W-1:0]            cps_ratio;
  logic [DEF_STEP_BITS-1:0]    steps_remaining;
  logic [DEF_PERIOD_BITS-1:0]  countdown;
  logic [DEF_PERIOD_BITS-1:0]  period_now;
  logic                        dir_cw;
  logic signed [31:0]          goal_angle;
  logic [DEF_ANGLE_BITS:0]     angle_now;
  logic                        moving_now;

  motor_status_t pending_status[$];
  int            error_count = 0;
  int            cycle_count = 0;

  // Divide by 2^16, rounding halves away from zero.
  function automatic longint round_half_away(longint v);
    if (v < 0)
      return -((-v + 64'sd32768) >>> 16);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint capped_magnitude(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return (m > STEP_CAP) ? STEP_CAP : m;
  endfunction

  // A jump of more than half a turn is taken as a wrap, and the tracked
  // angle is pinned to whichever end of the turn it came from.
  function automatic void track_encoder(logic [DEF_ANGLE_BITS-1:0] raw);
    longint diff;
    diff = longint'(angle_now) - longint'(raw);
    if (diff > HALF_TURN)
      angle_now = (DEF_ANGLE_BITS+1)'(FULL_TURN);
    else if (diff < -HALF_TURN)
      angle_now = '0;
    else
      angle_now = {1'b0, raw};
  endfunction

  function automatic longint steps_to_goal();
    return round_half_away((longint'(goal_angle) - longint'(angle_now)) *
                           longint'(spc_ratio));
  endfunction

  // A zero count stops the motor and keeps the old direction.
  function automatic void load_move(longint count, logic [DEF_PERIOD_BITS-1:0] period);
    period_now = (period == '0) ? DEF_PERIOD_BITS'(1) : period;
    countdown  = '0;
    if (count == 0) begin
      steps_remaining = '0;
      moving_now      = 1'b0;
    end else begin
      dir_cw          = (count < 0);
      steps_remaining = DEF_STEP_BITS'(capped_magnitude(count));
      moving_now      = 1'b1;
    end
  endfunction

  function automatic motor_status_t advance_motor(motor_item_t it);
    motor_status_t st;
    longint        needed;
    longint        miss;
    st.step_pulse   = 1'b0;
    st.at_target    = 1'b0;
    st.missed_steps = '0;
    case (it.kind)
      KIND_TICK: begin
        if (moving_now) begin
          if (steps_remaining == '0) begin
            moving_now = 1'b0;
          end else if (countdown == '0) begin
            st.step_pulse   = 1'b1;
            steps_remaining = steps_remaining - DEF_STEP_BITS'(1);
            countdown       = period_now - DEF_PERIOD_BITS'(1);
            if (steps_remaining == '0)
              moving_now = 1'b0;
          end else begin
            countdown = countdown - DEF_PERIOD_BITS'(1);
          end
        end
      end
      KIND_MOVE_STEPS: begin
        goal_angle = 32'(round_half_away(longint'(it.step_count) * longint'(cps_ratio)));
        load_move(longint'(it.step_count), it.period_ticks);
      end
      KIND_MOVE_ANGLE: begin
        goal_angle = 32'(it.target_angle);
        track_encoder(it.encoder_angle);
        load_move(steps_to_goal(), it.period_ticks);
      end
      default: begin
        // An encoder item never touches the direction or the moving flag.
        track_encoder(it.encoder_angle);
        needed = capped_magnitude(steps_to_goal());
        if (needed == 0) begin
          st.at_target = 1'b1;
        end else begin
          miss = needed - longint'(steps_remaining);
          if (miss > 64'sd8388607)
            miss = 64'sd8388607;
          if (miss < -64'sd8388608)
            miss = -64'sd8388608;
          st.missed_steps = miss[DEF_STEP_BITS-1:0];
          steps_remaining = DEF_STEP_BITS'(needed);
        end
      end
    endcase
    st.direction     = dir_cw;
    st.busy_res      = moving_now;
    st.steps_left    = steps_remaining;
    st.tracked_angle = angle_now;
    return st;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking. Everything is sampled at the rising edge. Within one
  // edge the result is checked before the item accepted at the same edge is
  // modelled, since a result can only belong to an earlier item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_watch
    motor_status_t want;
    motor_item_t   seen;
    if (rst) begin
      spc_ratio       = SPC_RESET;
      cps_ratio       = CPS_RESET;
      steps_remaining = '0;
      countdown       = '0;
      period_now      = DEF_PERIOD_BITS'(1);
      dir_cw          = 1'b1;
      goal_angle      = '0;
      angle_now       = '0;
      moving_now      = 1'b0;
      pending_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEPS_PER_COUNT: spc_ratio = cfg_data[SPC_W-1:0];
          CFG_COUNTS_PER_STEP: cps_ratio = cfg_data[CPS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          $error("result item with no input item outstanding");
          error_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("step_pulse", 32'(want.step_pulse), 32'(step_pulse));
          check_field("direction", 32'(want.direction), 32'(direction));
          check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
          check_field("at_target", 32'(want.at_target), 32'(at_target));
          check_field("missed_steps", 32'(want.missed_steps), 32'(missed_steps));
          check_field("steps_left", 32'(want.steps_left), 32'(steps_left));
          check_field("tracked_angle", 32'(want.tracked_angle), 32'(tracked_angle));
        end
      end
      if (in_valid && in_ready) begin
        seen.kind          = kind_t'(kind);
        seen.step_count    = step_count;
        seen.target_angle  = target_angle;
        seen.period_ticks  = period_ticks;
        seen.encoder_angle = encoder_angle;
        pending_status.push_back(advance_motor(seen));
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** stepper_move_with_encoder_check: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure. The ready line follows a rotating 16-bit
  // pattern which is redrawn whenever its random age runs out; some patterns
  // are all ones, so there are long stretches without any stall.
  // --------------------------------------------------------------------------
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_age = 0;

  always @(negedge clk) begin
    if (pattern_age == 0) begin
      pattern_age = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hFFFF;
        1:       ready_pattern = 16'($urandom);
        2:       ready_pattern = 16'($urandom | $urandom);
        default: ready_pattern = 16'($urandom & $urandom);
      endcase
      if (ready_pattern == '0)
        ready_pattern = 16'h0001;
    end
    pattern_age--;
    out_ready     = ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // --------------------------------------------------------------------------
  // Sending side. Items go out in bursts of random length; between bursts
  // the valid line drops for a random gap no longer than gap_max allows.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_max    = 6;

  task automatic send_item(motor_item_t it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      = 1'b1;
    kind          = it.kind;
    step_count    = it.step_count;
    target_angle  = it.target_angle;
    period_ticks  = it.period_ticks;
    encoder_angle = it.encoder_angle;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every outstanding result item has come
  // back, then idles on to let the pipeline drain.
  task automatic settle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ratio(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Ratios are only ever changed with the block drained.
  task automatic set_ratios(logic [CFG_DATA_W-1:0] spc, logic [CFG_DATA_W-1:0] cps);
    settle();
    write_ratio(CFG_STEPS_PER_COUNT, spc);
    write_ratio(CFG_COUNTS_PER_STEP, cps);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic motor_item_t item_of(kind_t k, int sc, int ta, int pt, int ea);
    motor_item_t it;
    it.kind          = k;
    it.step_count    = DEF_STEP_BITS'(sc);
    it.target_angle  = (DEF_ANGLE_BITS+1)'(ta);
    it.period_ticks  = DEF_PERIOD_BITS'(pt);
    it.encoder_angle = DEF_ANGLE_BITS'(ea);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic. Most of it is well formed: a move command followed by
  // roughly enough ticks to finish it, with the odd encoder item mixed in.
  // Encoder items mostly land near the last goal so that the block reports
  // arrival often; the rest are anywhere in the turn, which exercises the
  // wrap clamp. Fields that a kind ignores are random anyway.
  // --------------------------------------------------------------------------
  int aim_angle    = 0;
  int last_encoder = 0;
  int ticks_owed   = 0;

  function automatic logic [DEF_ANGLE_BITS-1:0] near_angle(int centre, int spread);
    int v;
    v = int'($urandom_range(0, 2 * spread));
    v = v + centre - spread;
    if (v < 0)
      v = 0;
    if (v > MAX_ANGLE)
      v = MAX_ANGLE;
    return v[DEF_ANGLE_BITS-1:0];
  endfunction

  function automatic logic [DEF_PERIOD_BITS-1:0] some_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return DEF_PERIOD_BITS'($urandom_range(0, 3));
    if (r < 95)
      return DEF_PERIOD_BITS'($urandom_range(4, 20));
    return DEF_PERIOD_BITS'($urandom);
  endfunction

  function automatic motor_item_t next_random_item();
    motor_item_t it;
    int          r;
    int          n;
    int          per;
    it.kind          = kind_t'($urandom_range(0, 3));
    it.step_count    = DEF_STEP_BITS'($urandom);
    it.target_angle  = (DEF_ANGLE_BITS+1)'($urandom_range(0, 1 << DEF_ANGLE_BITS));
    it.period_ticks  = DEF_PERIOD_BITS'($urandom);
    it.encoder_angle = DEF_ANGLE_BITS'($urandom);
    if (ticks_owed > 0) begin
      // Inside a move: mostly ticks, now and then an encoder check.
      ticks_owed--;
      if ($urandom_range(0, 9) != 0) begin
        it.kind = KIND_TICK;
      end else begin
        it.kind          = KIND_SAMPLE;
        it.encoder_angle = near_angle(aim_angle, 3);
        last_encoder     = int'(it.encoder_angle);
      end
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.kind         = KIND_MOVE_STEPS;
      it.period_ticks = some_period();
      per             = (it.period_ticks == '0) ? 1 : int'(it.period_ticks);
      if ($urandom_range(0, 9) != 0) begin
        n = $urandom_range(1, 16);
        ticks_owed = n * per + $urandom_range(0, 3);
        if ($urandom_range(0, 1) != 0)
          n = -n;
        it.step_count = DEF_STEP_BITS'(n);
      end else begin
        ticks_owed = $urandom_range(4, 40);
      end
      if (ticks_owed > 60)
        ticks_owed = 60;
    end else if (r < 70) begin
      it.kind = KIND_MOVE_ANGLE;
      if ($urandom_range(0, 3) != 0)
        aim_angle = int'(near_angle(last_encoder, 40));
      else
        aim_angle = $urandom_range(0, 1 << DEF_ANGLE_BITS);
      it.target_angle  = (DEF_ANGLE_BITS+1)'(aim_angle);
      it.encoder_angle = near_angle(last_encoder, 8);
      last_encoder     = int'(it.encoder_angle);
      it.period_ticks  = some_period();
      ticks_owed       = $urandom_range(4, 40);
    end else if (r < 85) begin
      it.kind = KIND_SAMPLE;
      r = $urandom_range(0, 9);
      if (r < 5)
        it.encoder_angle = near_angle(aim_angle, 2);
      else if (r < 8)
        it.encoder_angle = near_angle(last_encoder, 6);
      last_encoder = int'(it.encoder_angle);
    end
    // Anything else is left fully random as noise.
    return it;
  endfunction

  task automatic run_traffic(int count);
    repeat (count) send_item(next_random_item());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Moves by a step count: a zero period, a pulse train with a longer
  // period, a new move replacing one in progress, a zero count stopping the
  // motor without changing direction, and both saturating extremes.
  task automatic test_step_moves();
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_MOVE_STEPS, 2, 0, 0, 0));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_MOVE_STEPS, -3, 0, 2, 0));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_MOVE_STEPS, 5, 0, 65535, 0));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_MOVE_STEPS, 0, 0, 7, 0));
    send_item(item_of(KIND_MOVE_STEPS, -8388608, 0, 1, 0));
    send_item(item_of(KIND_MOVE_STEPS, 8388607, 0, 1, 0));
  endtask

  // Encoder items: clamping at both ends of the turn, a move to the full
  // turn, correction of the count, arrival, and a sample with the motor
  // stopped, after which a tick must still issue no step.
  task automatic test_encoder_samples();
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, MAX_ANGLE));
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, 2048));
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, 3000));
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, 100));
    send_item(item_of(KIND_MOVE_ANGLE, 0, 1 << DEF_ANGLE_BITS, 1, MAX_ANGLE));
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, MAX_ANGLE - 20));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    send_item(item_of(KIND_MOVE_ANGLE, 0, 2000, 3, 2000));
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, 2000));
    send_item(item_of(KIND_SAMPLE, 0, 0, 0, 2010));
    send_item(item_of(KIND_TICK, 0, 0, 0, 0));
    aim_angle    = 2000;
    last_encoder = 2010;
  endtask

  // Ratio extremes: both zero (upper data bits set, which the steps ratio
  // drops), both at full scale, and one half, where rounding of halves
  // shows up on every odd angle difference.
  task automatic test_ratio_extremes();
    set_ratios(24'hC00000, 24'h000000);
    run_traffic(150);
    set_ratios(24'hFFFFFF, 24'hFFFFFF);
    run_traffic(150);
    set_ratios(24'd32768, 24'd32768);
    run_traffic(150);
  endtask

  // Mixed traffic over unit and random ratios, one phase sent back to back
  // without gaps, ending on the reset values.
  task automatic test_mixed_traffic();
    gap_max = 0;
    set_ratios(24'd65536, 24'd65536);
    run_traffic(150);
    gap_max = 6;
    set_ratios(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    run_traffic(150);
    set_ratios(CFG_DATA_W'($urandom_range(1, 200000)), CFG_DATA_W'($urandom));
    run_traffic(150);
    set_ratios(CFG_DATA_W'(SPC_RESET), CPS_RESET);
    run_traffic(150);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_step_moves();
    test_encoder_samples();
    test_ratio_extremes();
    test_mixed_traffic();
    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("** stepper_move_with_encoder_check: PASSED **");
    else
      $display("** stepper_move_with_encoder_check: FAILED **");
    $finish;
  end

endmodule
